[rtl/ucu8_pkg.sv]
// Shared types, constants and a helper function of the user-comment decoder.
package ucu8_pkg;

    localparam int HDR_LEN    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] FMT_ASCII   = 3'd0;
    localparam logic [2:0] FMT_UNICODE = 3'd1;
    localparam logic [2:0] FMT_UNDEF   = 3'd2;
    localparam logic [2:0] FMT_UNSUP   = 3'd3;
    localparam logic [2:0] FMT_SHORT   = 3'd4;

    localparam logic [1:0] ORDER_AUTO = 2'd0;
    localparam logic [1:0] ORDER_LE   = 2'd1;
    localparam logic [1:0] ORDER_BE   = 2'd2;

    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [63:0] CODE_ASCII   = 64'h4153_4349_4900_0000;
    localparam logic [63:0] CODE_UNICODE = 64'h554E_4943_4F44_4500;
    localparam logic [63:0] CODE_ZERO    = 64'h0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic [2:0] format;
    } t_out_item;

    // One classified input byte: up to four UTF-8 bytes for the cleaner.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
        logic [2:0]      fmt;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_port;

    // Length of the UTF-8 sequence a byte opens; zero for a stray byte.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd0;
        if (c[7] == 1'b0) len = 3'd1;
        else if (c[7:5] == 3'b110) len = 3'd2;
        else if (c[7:4] == 4'b1110) len = 3'd3;
        else if (c[7:3] == 5'b11110) len = 3'd4;
        return len;
    endfunction

endpackage

[rtl/ucu8_fifo.sv]
// Two-entry queue between the classifying front end and the cleaning back end.
module ucu8_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ucu8_pkg::t_q_port i_wr,
    input  logic              i_pop,
    output ucu8_pkg::t_q_port o_rd,
    output logic              o_full
);
    import ucu8_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_entry r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          do_pop;

    assign do_pop = i_pop && (r_cnt != '0);
    assign o_full = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.entry = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr.valid) begin
            n_wp = (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (AW+1)'(i_wr.valid) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_wr.valid) begin
            r_mem[r_wp] <= i_wr.entry;
        end
    end
endmodule

[rtl/ucu8_front.sv]
// Front end: header recognition, UTF-16 unit assembly and UTF-8 encoding.
module ucu8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ucu8_pkg::t_in_item i_in_data,
    input  logic               i_full,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_data,
    output ucu8_pkg::t_q_port  o_wr
);
    import ucu8_pkg::*;

    logic [7:0]  r_hdr [HDR_LEN];
    logic [3:0]  r_count, n_count;
    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_order, n_order;
    logic [1:0]  r_byte_order;
    logic        r_held, n_held;
    logic [7:0]  r_half, n_half;
    logic        r_hp, n_hp;
    logic [9:0]  r_hs, n_hs;
    logic        r_stop, n_stop;

    logic        acc;
    logic [7:0]  b;
    logic [63:0] word;
    logic [15:0] u;
    logic [20:0] cp;
    logic [1:0]  uo;
    logic        done;
    t_entry      ent;

    assign acc = i_in_valid && !i_full;
    assign b   = i_in_data.in_byte;
    assign word = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3],
                   r_hdr[4], r_hdr[5], r_hdr[6], b};

    always_comb begin
        n_count = r_count;
        n_mode  = r_mode;
        n_order = r_order;
        n_held  = r_held;
        n_half  = r_half;
        n_hp    = r_hp;
        n_hs    = r_hs;
        n_stop  = r_stop;
        ent     = '0;
        u       = '0;
        cp      = '0;
        uo      = r_order;
        done    = 1'b0;
        if (acc) begin
            if (r_count < 4'(HDR_LEN)) begin
                n_count = r_count + 4'd1;
                if (r_count == 4'(HDR_LEN - 1)) begin
                    if (word == CODE_ASCII) n_mode = FMT_ASCII;
                    else if (word == CODE_UNICODE) n_mode = FMT_UNICODE;
                    else if (word == CODE_ZERO) n_mode = FMT_UNDEF;
                    else n_mode = FMT_UNSUP;
                    n_order = ((n_mode == FMT_UNICODE) &&
                               (r_byte_order == ORDER_LE || r_byte_order == ORDER_BE)) ?
                              r_byte_order : ORDER_AUTO;
                end
            end else if (r_mode == FMT_ASCII || r_mode == FMT_UNDEF) begin
                ent.bytes[0] = b;
                ent.count    = 3'd1;
            end else if (r_mode == FMT_UNICODE && !r_stop) begin
                if (!r_held) begin
                    n_half = b;
                    n_held = 1'b1;
                end else begin
                    n_held = 1'b0;
                    if (uo == ORDER_AUTO) begin
                        uo = (b == 8'd0 && r_half != 8'd0) ? ORDER_LE : ORDER_BE;
                    end
                    n_order = uo;
                    u = (uo == ORDER_LE) ? {b, r_half} : {r_half, b};
                    if (r_hp) begin
                        n_hp = 1'b0;
                        if (u[15:10] == 6'b110111) begin
                            cp = 21'h10000 + {1'b0, r_hs, u[9:0]};
                            ent.bytes[0] = {5'b11110, cp[20:18]};
                            ent.bytes[1] = {2'b10, cp[17:12]};
                            ent.bytes[2] = {2'b10, cp[11:6]};
                            ent.bytes[3] = {2'b10, cp[5:0]};
                            ent.count    = 3'd4;
                            done         = 1'b1;
                        end else begin
                            ent.bytes[0] = CHAR_QUESTION;
                            ent.count    = 3'd1;
                        end
                    end
                    if (!done) begin
                        if (u == 16'd0) begin
                            n_stop = 1'b1;
                        end else if (u[15:10] == 6'b110110) begin
                            n_hp = 1'b1;
                            n_hs = u[9:0];
                        end else begin
                            if (u[15:10] == 6'b110111) u = {8'd0, CHAR_QUESTION};
                            if (u < 16'h80) begin
                                ent.bytes[ent.count[1:0]] = u[7:0];
                                ent.count = ent.count + 3'd1;
                            end else if (u < 16'h800) begin
                                ent.bytes[ent.count[1:0]] = {3'b110, u[10:6]};
                                ent.count = ent.count + 3'd1;
                                ent.bytes[ent.count[1:0]] = {2'b10, u[5:0]};
                                ent.count = ent.count + 3'd1;
                            end else begin
                                ent.bytes[ent.count[1:0]] = {4'b1110, u[15:12]};
                                ent.count = ent.count + 3'd1;
                                ent.bytes[ent.count[1:0]] = {2'b10, u[11:6]};
                                ent.count = ent.count + 3'd1;
                                ent.bytes[ent.count[1:0]] = {2'b10, u[5:0]};
                                ent.count = ent.count + 3'd1;
                            end
                        end
                    end
                end
            end
            ent.fmt  = (r_count < 4'(HDR_LEN - 1)) ? FMT_SHORT : n_mode;
            ent.last = i_in_data.in_last;
            if (i_in_data.in_last) begin
                // A high surrogate left waiting at the end becomes a question mark.
                if (r_count >= 4'(HDR_LEN) && r_mode == FMT_UNICODE && !n_stop && n_hp) begin
                    ent.bytes[ent.count[1:0]] = CHAR_QUESTION;
                    ent.count = ent.count + 3'd1;
                end
                n_count = '0;
                n_mode  = FMT_ASCII;
                n_order = ORDER_AUTO;
                n_held  = 1'b0;
                n_half  = '0;
                n_hp    = 1'b0;
                n_hs    = '0;
                n_stop  = 1'b0;
            end
        end
    end

    assign o_wr.valid = acc && (ent.count != 3'd0 || i_in_data.in_last);
    assign o_wr.entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_mode       <= FMT_ASCII;
            r_order      <= ORDER_AUTO;
            r_held       <= 1'b0;
            r_half       <= '0;
            r_hp         <= 1'b0;
            r_hs         <= '0;
            r_stop       <= 1'b0;
            r_byte_order <= ORDER_AUTO;
        end else begin
            r_count <= n_count;
            r_mode  <= n_mode;
            r_order <= n_order;
            r_held  <= n_held;
            r_half  <= n_half;
            r_hp    <= n_hp;
            r_hs    <= n_hs;
            r_stop  <= n_stop;
            if (i_cfg_valid) begin
                r_byte_order <= i_cfg_data;
            end
        end
        if (acc && r_count < 4'(HDR_LEN)) begin
            r_hdr[r_count[2:0]] <= b;
        end
    end
endmodule

[rtl/ucu8_back.sv]
// Back end: UTF-8 cleaner and output register, at most one result byte per cycle, held while the output stalls.
module ucu8_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ucu8_pkg::t_q_port   i_rd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ucu8_pkg::t_out_item o_out_data
);
    import ucu8_pkg::*;

    logic        r_act, n_act;
    t_entry      r_ent, n_ent;
    logic [2:0]  r_j, n_j;
    logic [7:0]  r_lst [4];
    logic [7:0]  n_lst [4];
    logic [2:0]  r_cnt, n_cnt;
    logic        r_fin, n_fin;
    logic        r_bare, n_bare;
    logic [2:0]  r_lfmt, n_lfmt;
    logic [7:0]  r_p [3];
    logic [7:0]  n_p [3];
    logic [1:0]  r_m, n_m;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    logic        free, has_b, fin, alone;
    logic [7:0]  b;
    logic [2:0]  cnt, k;

    assign free  = !r_ov || !i_out_stall;
    assign o_pop = !r_act && i_rd.valid;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_act  = r_act;
        n_ent  = r_ent;
        n_j    = r_j;
        n_lst  = r_lst;
        n_fin  = r_fin;
        n_bare = r_bare;
        n_lfmt = r_lfmt;
        n_p    = r_p;
        n_m    = r_m;
        n_ov   = r_ov && !free;
        n_out  = r_out;
        cnt    = r_cnt;
        k      = '0;
        alone  = 1'b0;
        b      = r_ent.bytes[r_j[1:0]];
        has_b  = (r_j < r_ent.count);
        fin    = r_ent.last && ((r_j + 3'd1) >= r_ent.count);
        if (r_cnt != 3'd0 && free) begin
            n_out.out_byte   = r_lst[0];
            n_out.byte_valid = !r_bare;
            n_out.out_last   = r_fin && (r_cnt == 3'd1);
            n_out.format     = r_lfmt;
            n_ov             = 1'b1;
            n_lst[0] = r_lst[1];
            n_lst[1] = r_lst[2];
            n_lst[2] = r_lst[3];
            cnt      = r_cnt - 3'd1;
        end
        n_cnt = cnt;
        if (cnt == 3'd0 && r_act) begin
            if (has_b) begin
                if (r_m == 2'd0) begin
                    alone = 1'b1;
                end else if (b[7:6] == 2'b10) begin
                    if (({1'b0, r_m} + 3'd1) == seq_len(r_p[0])) begin
                        for (int i = 0; i < 3; i++) begin
                            if (2'(i) < r_m) begin
                                n_lst[k[1:0]] = r_p[i];
                                k = k + 3'd1;
                            end
                        end
                        n_lst[k[1:0]] = b;
                        k   = k + 3'd1;
                        n_m = 2'd0;
                    end else begin
                        n_p[r_m] = b;
                        n_m      = r_m + 2'd1;
                    end
                end else begin
                    // A broken sequence: every held byte turns into a question mark.
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < r_m) begin
                            n_lst[k[1:0]] = CHAR_QUESTION;
                            k = k + 3'd1;
                        end
                    end
                    n_m   = 2'd0;
                    alone = 1'b1;
                end
                if (alone) begin
                    if (b[7] == 1'b0) begin
                        n_lst[k[1:0]] = (b < 8'h20 && b != 8'h09 && b != 8'h0A) ?
                                        CHAR_QUESTION : b;
                        k = k + 3'd1;
                    end else if (seq_len(b) == 3'd0) begin
                        n_lst[k[1:0]] = CHAR_QUESTION;
                        k = k + 3'd1;
                    end else begin
                        n_p[0] = b;
                        n_m    = 2'd1;
                    end
                end
            end
            if (fin) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < n_m) begin
                        n_lst[k[1:0]] = CHAR_QUESTION;
                        k = k + 3'd1;
                    end
                end
                n_m = 2'd0;
            end
            n_cnt  = k;
            n_fin  = fin;
            n_bare = 1'b0;
            n_lfmt = r_ent.fmt;
            if (fin && k == 3'd0) begin
                n_lst[0] = 8'd0;
                n_cnt    = 3'd1;
                n_bare   = 1'b1;
            end
            n_j = r_j + 3'd1;
            if (fin || (r_j + 3'd1) == r_ent.count) begin
                n_act = 1'b0;
            end
        end
        if (o_pop) begin
            n_ent = i_rd.entry;
            n_j   = '0;
            n_act = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
            r_m   <= '0;
            r_ov  <= 1'b0;
            r_fin <= 1'b0;
            r_bare <= 1'b0;
        end else begin
            r_act <= n_act;
            r_cnt <= n_cnt;
            r_m   <= n_m;
            r_ov  <= n_ov;
            r_fin <= n_fin;
            r_bare <= n_bare;
        end
        r_ent  <= n_ent;
        r_j    <= n_j;
        r_lst  <= n_lst;
        r_lfmt <= n_lfmt;
        r_p    <= n_p;
        r_out  <= n_out;
    end
endmodule

[rtl/user_comment_to_utf8_decoder.sv]
// Top level of the user-comment to UTF-8 decoder.
// The block takes one raw byte of an image user-comment field per input transfer, header first,
// and delivers cleaned UTF-8 bytes, one per output transfer. The eight header bytes select the
// charset: ASCII and all-zero codes are cleaned, UNICODE is decoded from UTF-16 in the byte order
// held in the configuration register (autodetect, little or big endian), and any other code or a
// stream shorter than eight bytes gives only a bare end item. The front end accepts one byte per
// cycle while its two-entry queue has room; header bytes, the first byte of a UTF-16 unit and
// ignored bytes leave nothing in the queue unless they end the stream. The back end takes an
// entry from the queue and then works through the UTF-8 bytes in it one at a time, each only once
// the results of the one before have moved into the output register; it takes the next entry once
// it has worked through the last byte of the previous one. The output register sends at most one
// result per cycle and holds it while the output stalls. The first result of a byte passes through
// the queue, the entry register of the back end, its result list and the output register. Output
// stalls hold the back end and, once the queue is full, the input. The byte order is sampled at
// the eighth byte of each stream; the register is written through its own transfer channel, which
// is always ready.
module user_comment_to_utf8_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ucu8_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ucu8_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data
);
    import ucu8_pkg::*;

    t_q_port q_wr;
    t_q_port q_rd;
    logic    q_full;
    logic    q_pop;

    // The queue being full is the only reason to hold off an input transfer.
    assign o_in_stall  = q_full;
    assign o_cfg_ready = 1'b1;

    ucu8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_full      (q_full),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (q_wr)
    );

    ucu8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    // The back end cleans the queued bytes and owns the output register.
    ucu8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

[rtl/ucu8_checker.sv]
// Port-level checker of the decoder, bound to its top level.
module ucu8_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ucu8_pkg::t_out_item o_out_data,
    input logic                o_cfg_ready
);
    import ucu8_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |-> o_out_data.out_last &&
        o_out_data.out_byte == 8'd0)
        else $error("bare end item without end mark or with data");

    a_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.format <= FMT_SHORT)
        else $error("format code out of range");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");
endmodule

bind user_comment_to_utf8_decoder ucu8_checker u_ucu8_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

[bench/tb_user_comment_to_utf8_decoder.sv]
// Self-checking bench for the user-comment decoder, directed and random stimulus against a built-in predictor.
module tb_user_comment_to_utf8_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ucu8_pkg::*;

    // Clock, reset and the ports of the block.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data = ORDER_AUTO;

    always #5 i_clk = ~i_clk;

    user_comment_to_utf8_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Byte sequences waiting for the driver, and the output bytes the decoder must deliver.
    t_in_item  byte_queue[$];
    t_out_item utf8_expected[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // The predictor's own copy of the register and of the stream state.
    logic [1:0]  order_reg;
    logic [7:0]  hdr[8];
    int          hdr_count;
    logic [2:0]  charset;
    logic [1:0]  unit_ord;
    logic [7:0]  held_utf8[3];
    int          held_count;
    bit          half_valid;
    logic [7:0]  half_byte;
    bit          high_valid;
    logic [15:0] high_bits;
    bit          zero_seen;
    logic [7:0]  step_bytes[$];

    function automatic int lead_len(logic [7:0] c);
        if (c[7] == 1'b0) return 1;
        if (c[7:5] == 3'b110) return 2;
        if (c[7:4] == 4'b1110) return 3;
        if (c[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    // Appends one predicted output byte for the current step.
    function automatic void note_byte(logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    function automatic void stream_clear();
        for (int i = 0; i < 8; i++) hdr[i] = '0;
        hdr_count = 0;
        charset = FMT_ASCII;
        unit_ord = ORDER_AUTO;
        held_count = 0;
        half_valid = 1'b0;
        half_byte = '0;
        high_valid = 1'b0;
        high_bits = '0;
        zero_seen = 1'b0;
    endfunction

    // Cleans a window of bytes; an unfinished sequence is held back unless the stream ends.
    function automatic void clean_window(logic [7:0] w[$], bit fin);
        int s;
        int n;
        int len;
        bit ok;
        s = 0;
        n = w.size();
        while (s < n) begin
            len = lead_len(w[s]);
            if (len == 1) begin
                note_byte((w[s] < 8'h20 && w[s] != 8'h09 && w[s] != 8'h0A)
                          ? CHAR_QUESTION : w[s]);
                s++;
                continue;
            end
            if (len == 0) begin
                note_byte(CHAR_QUESTION);
                s++;
                continue;
            end
            ok = 1'b1;
            for (int k = 1; k < len && k < n - s; k++)
                if (w[s + k][7:6] != 2'b10) ok = 1'b0;
            if (!ok) begin
                note_byte(CHAR_QUESTION);
                s++;
            end else if (n - s >= len) begin
                for (int k = 0; k < len; k++) note_byte(w[s + k]);
                s += len;
            end else if (fin) begin
                note_byte(CHAR_QUESTION);
                s++;
            end else begin
                break;
            end
        end
        held_count = 0;
        while (s < n && held_count < 3) begin
            held_utf8[held_count] = w[s];
            held_count++;
            s++;
        end
    endfunction

    function automatic void clean_byte(logic [7:0] b);
        logic [7:0] w[$];
        for (int k = 0; k < held_count; k++) w = {w, held_utf8[k]};
        w = {w, b};
        clean_window(w, 1'b0);
    endfunction

    function automatic void clean_end();
        logic [7:0] w[$];
        for (int k = 0; k < held_count; k++) w = {w, held_utf8[k]};
        clean_window(w, 1'b1);
    endfunction

    function automatic void encode_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            clean_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            clean_byte({3'b110, cp[10:6]});
            clean_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            clean_byte({4'b1110, cp[15:12]});
            clean_byte({2'b10, cp[11:6]});
            clean_byte({2'b10, cp[5:0]});
        end else begin
            clean_byte({5'b11110, cp[20:18]});
            clean_byte({2'b10, cp[17:12]});
            clean_byte({2'b10, cp[11:6]});
            clean_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void decode_unit(logic [15:0] u);
        if (high_valid) begin
            high_valid = 1'b0;
            if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                encode_point(21'h10000 + {high_bits[9:0], 10'd0} + (u - 16'hDC00));
                return;
            end
            encode_point(21'(CHAR_QUESTION));
        end
        if (u == 16'h0) begin
            zero_seen = 1'b1;
            return;
        end
        if (u >= 16'hD800 && u <= 16'hDBFF) begin
            high_valid = 1'b1;
            high_bits = u - 16'hD800;
            return;
        end
        if (u >= 16'hDC00 && u <= 16'hDFFF) u = 16'(CHAR_QUESTION);
        encode_point(21'(u));
    endfunction

    // Works out the output bytes one accepted input byte causes, keeping at most six of them.
    function automatic void predict_utf8(t_in_item it);
        logic [63:0] code;
        logic [15:0] u;
        logic [2:0]  fmt;
        t_out_item   r;
        int          n;
        step_bytes.delete();
        if (hdr_count < HDR_LEN) begin
            hdr[hdr_count] = it.in_byte;
            hdr_count++;
            if (hdr_count == HDR_LEN) begin
                code = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]};
                if (code == CODE_ASCII) charset = FMT_ASCII;
                else if (code == CODE_UNICODE) charset = FMT_UNICODE;
                else if (code == CODE_ZERO) charset = FMT_UNDEF;
                else charset = FMT_UNSUP;
                unit_ord = (charset == FMT_UNICODE &&
                            (order_reg == ORDER_LE || order_reg == ORDER_BE))
                           ? order_reg : ORDER_AUTO;
            end
        end else if (charset == FMT_ASCII || charset == FMT_UNDEF) begin
            clean_byte(it.in_byte);
        end else if (charset == FMT_UNICODE && !zero_seen) begin
            if (!half_valid) begin
                half_byte = it.in_byte;
                half_valid = 1'b1;
            end else begin
                half_valid = 1'b0;
                if (unit_ord == ORDER_AUTO)
                    unit_ord = (it.in_byte == 8'h0 && half_byte != 8'h0) ? ORDER_LE : ORDER_BE;
                u = (unit_ord == ORDER_LE) ? {it.in_byte, half_byte} : {half_byte, it.in_byte};
                decode_unit(u);
            end
        end
        fmt = (hdr_count < HDR_LEN) ? FMT_SHORT : charset;
        if (it.in_last && hdr_count >= HDR_LEN) begin
            if (charset == FMT_UNICODE && !zero_seen && high_valid)
                encode_point(21'(CHAR_QUESTION));
            clean_end();
        end
        n = (step_bytes.size() > 6) ? 6 : step_bytes.size();
        if (it.in_last && n == 0) begin
            r = '{out_byte: 8'h0, byte_valid: 1'b0, out_last: 1'b1, format: fmt};
            utf8_expected = {utf8_expected, r};
        end
        for (int k = 0; k < n; k++) begin
            r = '{out_byte: step_bytes[k], byte_valid: 1'b1,
                  out_last: it.in_last && k == n - 1, format: fmt};
            utf8_expected = {utf8_expected, r};
        end
        if (it.in_last) stream_clear();
    endfunction

    // Driver: one byte per transfer with a random gap before each; prediction at acceptance.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_utf8(i_in_data);
                void'(byte_queue.pop_front());
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 4) == 0) in_gap = 0;
                if (in_gap == 0 && byte_queue.size() > 0) begin
                    i_in_data <= byte_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (byte_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= byte_queue[0];
                end
            end
        end
    end

    // Monitor: random stall per output transfer; each accepted byte meets the oldest expectation.
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (utf8_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output %h", o_out_data);
                end else begin
                    if (o_out_data !== utf8_expected[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                                     utf8_expected[0].out_byte, utf8_expected[0].byte_valid,
                                     utf8_expected[0].out_last, utf8_expected[0].format,
                                     o_out_data.out_byte, o_out_data.byte_valid,
                                     o_out_data.out_last, o_out_data.format);
                    end
                    void'(utf8_expected.pop_front());
                end
                out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hard limit on the run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 800000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stream builders used by the stimulus.
    task automatic add_byte(logic [7:0] b, bit last);
        t_in_item it;
        it.in_byte = b;
        it.in_last = last;
        byte_queue = {byte_queue, it};
    endtask

    task automatic add_header(logic [63:0] code);
        for (int i = 7; i >= 0; i--) add_byte(code[i*8 +: 8], 1'b0);
    endtask

    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(8'h20, 8'h7E));
            1: return 8'($urandom_range(8'hC0, 8'hF7));
            2, 3: return 8'($urandom_range(8'h80, 8'hBF));
            4: return 8'($urandom_range(0, 8'h1F));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_stream();
        int kind;
        int len;
        logic [15:0] u;
        bit le;
        kind = $urandom_range(0, 9);
        le = $urandom_range(0, 1);
        len = $urandom_range(1, 12);
        if (kind <= 2) begin
            add_header(kind == 2 ? CODE_ZERO : CODE_ASCII);
            for (int i = 0; i < len; i++) add_byte(random_text_byte(), i == len - 1);
        end else if (kind <= 6) begin
            add_header(CODE_UNICODE);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 6))
                    0: u = 16'($urandom_range(8'h01, 8'h7F));
                    1: u = 16'($urandom_range(16'h80, 16'h7FF));
                    2: u = 16'($urandom_range(16'hD800, 16'hDBFF));
                    3: u = 16'($urandom_range(16'hDC00, 16'hDFFF));
                    4: u = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
                    default: u = 16'($urandom);
                endcase
                if (le) begin
                    add_byte(u[7:0], 1'b0);
                    add_byte(u[15:8], i == len - 1 && $urandom_range(0, 4) != 0);
                end else begin
                    add_byte(u[15:8], 1'b0);
                    add_byte(u[7:0], i == len - 1 && $urandom_range(0, 4) != 0);
                end
            end
            if (!byte_queue[$].in_last) add_byte(8'($urandom), 1'b1);
        end else if (kind == 7) begin
            add_header({$urandom, $urandom});
            for (int i = 0; i < len; i++) add_byte(8'($urandom), i == len - 1);
        end else begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) add_byte(8'($urandom), i == len - 1);
        end
    endtask

    // Waits for the decoder to drain before the register changes.
    task automatic wait_drained();
        while (byte_queue.size() > 0 || i_in_valid || utf8_expected.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_order(logic [1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        order_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        order_reg = ORDER_AUTO;
        stream_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ASCII with controls, tab, newline and a cut multibyte sequence at the end.
        add_header(CODE_ASCII);
        add_byte(8'h41, 1'b0); add_byte(8'h09, 1'b0); add_byte(8'h0A, 1'b0);
        add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        // Header-only stream gives a bare end item, then a too-short one.
        add_header(CODE_ZERO);
        byte_queue[$].in_last = 1'b1;
        add_byte(8'h55, 1'b1);
        // UNICODE autodetected little endian, a surrogate pair, a lone high at the end.
        add_header(CODE_UNICODE);
        add_byte(8'h41, 1'b0); add_byte(8'h00, 1'b0);
        add_byte(8'h3D, 1'b0); add_byte(8'hD8, 1'b0);
        add_byte(8'h00, 1'b0); add_byte(8'hDE, 1'b0);
        add_byte(8'hFF, 1'b0); add_byte(8'hDB, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            write_order(phase == 0 ? ORDER_LE : phase == 1 ? ORDER_BE :
                        phase == 2 ? 2'd3 : 2'($urandom_range(0, 3)));
            if (phase < 2) begin
                // Zero unit stops the stream; a pending high surrogate turns into '?'.
                add_header(CODE_UNICODE);
                add_byte(8'hD8, 1'b0); add_byte(8'hD8, 1'b0);
                add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
                add_byte(8'h41, 1'b1);
            end
            while (byte_queue.size() < 25) random_stream();
            wait_drained();
        end
        write_order(ORDER_AUTO);

        if (mismatch_count == 0 && utf8_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[user_comment_to_utf8_decoder.f]
rtl/ucu8_pkg.sv
rtl/ucu8_fifo.sv
rtl/ucu8_front.sv
rtl/ucu8_back.sv
rtl/user_comment_to_utf8_decoder.sv
rtl/ucu8_checker.sv
bench/tb_user_comment_to_utf8_decoder.sv
